/* sv/pkup_pkg.sv */
// Shared types and constants for the PKCS#1 v1.5 unpad stream unit.
package pkup_pkg;

  localparam int unsigned MAX_BLOCK_BYTES = 256;
  localparam int unsigned MIN_PAD         = 8;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);

  localparam logic [8:0] POS_SAT = 9'd511;

  localparam logic [1:0] REG_BLOCK_TYPE   = 2'd0;
  localparam logic [1:0] REG_BLOCK_LENGTH = 2'd1;
  localparam logic [1:0] REG_CAPACITY     = 2'd2;

  localparam logic [1:0] RESET_BLOCK_TYPE   = 2'd2;
  localparam logic [8:0] RESET_BLOCK_LENGTH = 9'd256;
  localparam logic [8:0] RESET_CAPACITY     = 9'd256;

  localparam logic [7:0] TYPE_PRIVATE = 8'h01;
  localparam logic [7:0] TYPE_PUBLIC  = 8'h02;
  localparam logic [7:0] PAD_FF       = 8'hff;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_TYPE  = 3'd1,
    ST_NO_SEP    = 3'd2,
    ST_SHORT_PAD = 3'd3,
    ST_BAD_PAD   = 3'd4,
    ST_TOO_LONG  = 3'd5,
    ST_BAD_LEN   = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0] block_type;
    logic [8:0] block_length;
    logic [8:0] capacity;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    status_t    status;
    logic [8:0] length;
    logic       done;
  } result_t;

  // Up to two results per accepted byte, written to the queue in order a, b.
  typedef struct packed {
    logic [1:0] count;
    result_t    a;
    result_t    b;
  } push_t;

endpackage

/* sv/pkup_core.sv */
// Per-byte padding check: block state registers and the single-pass step logic.
module pkup_core #(
  parameter int unsigned MaxBlockBytes = pkup_pkg::MAX_BLOCK_BYTES
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      data_in,
  input  logic            last_in,
  input  pkup_pkg::cfg_t  cfg,
  output pkup_pkg::push_t push
);

  typedef enum logic [4:0] {
    PH_LEAD  = 5'b00001,
    PH_TYPE  = 5'b00010,
    PH_PAD   = 5'b00100,
    PH_DATA  = 5'b01000,
    PH_DRAIN = 5'b10000
  } phase_t;

  localparam logic [9:0] MaxLimit = 10'(MaxBlockBytes);

  phase_t            phase, phase_next;
  logic [8:0]        pos, pos_next;
  logic [8:0]        pad_count, pad_count_next;
  logic [8:0]        pay_count, pay_count_next;
  pkup_pkg::status_t err, err_next;

  logic              bad_len_now;
  logic              type_ok;
  logic              emit;
  pkup_pkg::status_t final_status;
  pkup_pkg::result_t pay_res, stat_res;

  assign bad_len_now = ({1'b0, pos} >= {1'b0, cfg.block_length}) || ({1'b0, pos} >= MaxLimit);
  assign type_ok = ((cfg.block_type == 2'd1) && (data_in == pkup_pkg::TYPE_PRIVATE)) ||
                   ((cfg.block_type == 2'd2) && (data_in == pkup_pkg::TYPE_PUBLIC));

  always_comb begin
    phase_next     = phase;
    pad_count_next = pad_count;
    pay_count_next = pay_count;
    emit           = 1'b0;
    err_next       = bad_len_now ? pkup_pkg::ST_BAD_LEN : err;
    unique case (phase)
      PH_LEAD: phase_next = PH_TYPE;
      PH_TYPE: begin
        if (type_ok) begin
          phase_next = PH_PAD;
        end else begin
          if (err_next == pkup_pkg::ST_OK) err_next = pkup_pkg::ST_BAD_TYPE;
          phase_next = PH_DRAIN;
        end
      end
      PH_PAD: begin
        priority if (data_in == 8'd0) begin
          if (pad_count < 9'(pkup_pkg::MIN_PAD) && err_next == pkup_pkg::ST_OK) begin
            err_next = pkup_pkg::ST_SHORT_PAD;
          end
          phase_next = PH_DATA;
        end else if (cfg.block_type == 2'd1 && data_in != pkup_pkg::PAD_FF) begin
          if (err_next == pkup_pkg::ST_OK) err_next = pkup_pkg::ST_BAD_PAD;
          phase_next = PH_DRAIN;
        end else if (pad_count < pkup_pkg::POS_SAT) begin
          pad_count_next = pad_count + 9'd1;
        end
      end
      PH_DATA: begin
        if (err_next == pkup_pkg::ST_OK) begin
          if (pay_count >= cfg.capacity) begin
            err_next = pkup_pkg::ST_TOO_LONG;
          end else begin
            emit           = 1'b1;
            pay_count_next = pay_count + 9'd1;
          end
        end
      end
      PH_DRAIN: ;
      default: ;
    endcase
  end

  assign pos_next = (pos == pkup_pkg::POS_SAT) ? pos : pos + 9'd1;

  always_comb begin
    priority if (err_next == pkup_pkg::ST_BAD_LEN ||
                 ({1'b0, pos} + 10'd1) != {1'b0, cfg.block_length}) begin
      final_status = pkup_pkg::ST_BAD_LEN;
    end else if (err_next != pkup_pkg::ST_OK) begin
      final_status = err_next;
    end else if (phase_next == PH_DATA) begin
      final_status = pkup_pkg::ST_OK;
    end else if (phase_next == PH_PAD) begin
      final_status = pkup_pkg::ST_NO_SEP;
    end else begin
      final_status = pkup_pkg::ST_BAD_TYPE;
    end
  end

  always_comb begin
    pay_res.kind   = 1'b0;
    pay_res.data   = data_in;
    pay_res.status = pkup_pkg::ST_OK;
    pay_res.length = 9'd0;
    pay_res.done   = ~last_in;

    stat_res.kind   = 1'b1;
    stat_res.data   = 8'd0;
    stat_res.status = final_status;
    stat_res.length = pay_count_next;
    stat_res.done   = 1'b1;

    push.a     = emit ? pay_res : stat_res;
    push.b     = stat_res;
    push.count = accept ? ({1'b0, emit} + {1'b0, last_in}) : 2'd0;
  end

  // Clear the block state after the status result.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LEAD;
      pos       <= 9'd0;
      pad_count <= 9'd0;
      pay_count <= 9'd0;
      err       <= pkup_pkg::ST_OK;
    end else if (accept) begin
      if (last_in) begin
        phase     <= PH_LEAD;
        pos       <= 9'd0;
        pad_count <= 9'd0;
        pay_count <= 9'd0;
        err       <= pkup_pkg::ST_OK;
      end else begin
        phase     <= phase_next;
        pos       <= pos_next;
        pad_count <= pad_count_next;
        pay_count <= pay_count_next;
        err       <= err_next;
      end
    end
  end

endmodule

/* sv/pkup_queue.sv */
// Result queue: takes up to two results per cycle, hands out one per cycle while pop is high.
module pkup_queue (
  input  logic              clk,
  input  logic              rst,
  input  pkup_pkg::push_t   push,
  input  logic              pop,
  output pkup_pkg::result_t head,
  output logic              valid,
  output logic              room
);

  localparam int unsigned PtrW = pkup_pkg::QUEUE_PTR_W;

  pkup_pkg::result_t mem [pkup_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [PtrW:0]     count, count_next;
  logic [PtrW-1:0]   wr_ptr_b;

  assign valid    = (count != '0);
  // Keep space for a two-result request.
  assign room     = (count <= (PtrW+1)'(pkup_pkg::QUEUE_DEPTH - 2));
  assign head     = mem[rd_ptr];
  assign wr_ptr_b = wr_ptr + PtrW'(1);
  assign count_next = count + (PtrW+1)'(push.count) - (PtrW+1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push.count);
      if (pop) rd_ptr <= rd_ptr + PtrW'(1);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.a;
    if (push.count == 2'd2) mem[wr_ptr_b] <= push.b;
  end

endmodule

/* sv/pkcs1_v15_unpad_stream_unit.sv */
// Top level of the streaming PKCS#1 v1.5 padding check.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  input    | in_valid / in_stall    | in_byte, in_last
//  output   | out_valid / out_stall  | out_kind, out_byte, out_status, out_length,
//           |                        | out_end
//  config   | cfg_en (write only)    | cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; its results are written to a four-entry
// queue at the accepting edge and show on the output from the next cycle on.
// A final byte that also carries payload yields two results; the queue absorbs the
// extra one, so with out_stall low the input is never stalled.
// in_stall rises when the queue has fewer than two free entries.
// Reset (rst, synchronous) clears block state and queue and restores the register defaults.
module pkcs1_v15_unpad_stream_unit #(
  parameter int unsigned MaxBlockBytes = pkup_pkg::MAX_BLOCK_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_byte,
  output logic [2:0] out_status,
  output logic [8:0] out_length,
  output logic       out_end,
  input  logic       cfg_en,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  pkup_pkg::cfg_t    cfg;
  pkup_pkg::push_t   push;
  pkup_pkg::result_t head;
  logic              accept;
  logic              room;
  logic              pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_type   <= pkup_pkg::RESET_BLOCK_TYPE;
      cfg.block_length <= pkup_pkg::RESET_BLOCK_LENGTH;
      cfg.capacity     <= pkup_pkg::RESET_CAPACITY;
    end else if (cfg_en) begin
      unique case (cfg_index)
        pkup_pkg::REG_BLOCK_TYPE:   cfg.block_type   <= cfg_data[1:0];
        pkup_pkg::REG_BLOCK_LENGTH: cfg.block_length <= cfg_data;
        pkup_pkg::REG_CAPACITY:     cfg.capacity     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = ~room;
  assign accept   = in_valid & room;
  assign pop      = out_valid & ~out_stall;

  pkup_core #(
    .MaxBlockBytes(MaxBlockBytes)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .data_in (in_byte),
    .last_in (in_last),
    .cfg     (cfg),
    .push    (push)
  );

  pkup_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .valid (out_valid),
    .room  (room)
  );

  assign out_kind   = head.kind;
  assign out_byte   = head.data;
  assign out_status = head.status;
  assign out_length = head.length;
  assign out_end    = head.done;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for pkcs1_v15_unpad_stream_unit: directed blocks, then random ones.
module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 20;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam logic [1:0] BT_NONE     = 2'd0;
  localparam logic [1:0] BT_PRIVATE  = 2'd1;
  localparam logic [1:0] BT_PUBLIC   = 2'd2;
  localparam logic [1:0] BT_RESERVED = 2'd3;

  localparam logic [7:0] SEPARATOR = 8'h00;

  // Block shapes for the random part; lower values build blocks with no corruption, noise or cut.
  localparam int SHAPE_CORRUPT = 6;
  localparam int SHAPE_NOISE   = 7;
  localparam int SHAPE_CUT     = 8;
  localparam int SHAPE_LONG    = 9;

  typedef enum logic [2:0] {
    SCAN_LEAD, SCAN_TYPE, SCAN_PAD, SCAN_DATA, SCAN_DRAIN
  } scan_phase_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic       out_kind;
  logic [7:0] out_byte;
  logic [2:0] out_status;
  logic [8:0] out_length;
  logic       out_end;
  logic       cfg_en;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;

  // Register copies and block state of the unpad predictor.
  logic [1:0]         type_m;
  logic [8:0]         len_m;
  logic [8:0]         cap_m;
  scan_phase_t        scan_phase;
  logic [8:0]         pos;
  logic [8:0]         pad_cnt;
  logic [8:0]         pay_cnt;
  pkup_pkg::status_t  err;

  pkup_pkg::result_t pending_results[$];
  logic [7:0]        blk[$];

  int   mismatches   = 0;
  int   stuck_cycles = 0;
  int   stall_left   = 0;
  logic quiet        = 1'b0;
  logic result_taken = 1'b0;

  pkcs1_v15_unpad_stream_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_wait();
    if (quiet) return 0;
    return $urandom_range(0, 8);
  endfunction

  task automatic clear_scan();
    scan_phase = SCAN_LEAD;
    pos        = '0;
    pad_cnt    = '0;
    pay_cnt    = '0;
    err        = pkup_pkg::ST_OK;
  endtask

  task automatic flag_first_error(input pkup_pkg::status_t code);
    if (err == pkup_pkg::ST_OK) err = code;
  endtask

  task automatic predict_unpad(input logic [7:0] b, input logic is_last);
    logic [8:0]        idx;
    logic              emit;
    pkup_pkg::status_t st;
    pkup_pkg::result_t r;
    idx  = pos;
    emit = 1'b0;
    if (idx >= len_m || idx >= pkup_pkg::MAX_BLOCK_BYTES) err = pkup_pkg::ST_BAD_LEN;
    case (scan_phase)
      SCAN_LEAD: scan_phase = SCAN_TYPE;
      SCAN_TYPE: begin
        if (b != 8'(type_m) ||
            (b != pkup_pkg::TYPE_PRIVATE && b != pkup_pkg::TYPE_PUBLIC)) begin
          flag_first_error(pkup_pkg::ST_BAD_TYPE);
          scan_phase = SCAN_DRAIN;
        end else begin
          scan_phase = SCAN_PAD;
        end
      end
      SCAN_PAD: begin
        if (b == SEPARATOR) begin
          if (pad_cnt < pkup_pkg::MIN_PAD) flag_first_error(pkup_pkg::ST_SHORT_PAD);
          scan_phase = SCAN_DATA;
        end else if (8'(type_m) == pkup_pkg::TYPE_PRIVATE && b != pkup_pkg::PAD_FF) begin
          flag_first_error(pkup_pkg::ST_BAD_PAD);
          scan_phase = SCAN_DRAIN;
        end else if (pad_cnt < pkup_pkg::POS_SAT) begin
          pad_cnt++;
        end
      end
      SCAN_DATA: begin
        if (err == pkup_pkg::ST_OK) begin
          if (pay_cnt >= cap_m) begin
            flag_first_error(pkup_pkg::ST_TOO_LONG);
          end else begin
            emit = 1'b1;
            pay_cnt++;
          end
        end
      end
      default: ;
    endcase
    if (pos < pkup_pkg::POS_SAT) pos++;
    if (emit) begin
      r.kind   = 1'b0;
      r.data   = b;
      r.status = pkup_pkg::ST_OK;
      r.length = '0;
      r.done   = !is_last;
      pending_results.push_back(r);
    end
    if (is_last) begin
      if (err == pkup_pkg::ST_BAD_LEN || ({1'b0, idx} + 10'd1) != {1'b0, len_m})
        st = pkup_pkg::ST_BAD_LEN;
      else if (err != pkup_pkg::ST_OK) st = err;
      else if (scan_phase == SCAN_DATA) st = pkup_pkg::ST_OK;
      else if (scan_phase == SCAN_PAD) st = pkup_pkg::ST_NO_SEP;
      else st = pkup_pkg::ST_BAD_TYPE;
      r.kind   = 1'b1;
      r.data   = '0;
      r.status = st;
      r.length = pay_cnt;
      r.done   = 1'b1;
      pending_results.push_back(r);
      clear_scan();
    end
  endtask

  // Hold the request until the unit takes it, then predict its results.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int   gap;
    logic ok;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= is_last;
    forever begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
      if (ok) break;
    end
    predict_unpad(b, is_last);
  endtask

  task automatic send_block();
    foreach (blk[i]) send_byte(blk[i], i == blk.size() - 1);
  endtask

  // Writes every register; first waits until the unit has drained.
  task automatic set_config(input logic [1:0] bt, input logic [8:0] len, input logic [8:0] cap);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_en    <= 1'b1;
    cfg_index <= pkup_pkg::REG_BLOCK_TYPE;
    cfg_data  <= {7'd0, bt};
    @(posedge clk);
    cfg_index <= pkup_pkg::REG_BLOCK_LENGTH;
    cfg_data  <= len;
    @(posedge clk);
    cfg_index <= pkup_pkg::REG_CAPACITY;
    cfg_data  <= cap;
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data  <= 9'($urandom_range(0, 511));
    @(posedge clk);
    cfg_en <= 1'b0;
    type_m = bt;
    len_m  = len;
    cap_m  = cap;
  endtask

  task automatic build_wellformed(input int total);
    int pad_len;
    blk.delete();
    blk.push_back(8'($urandom_range(0, 255)));
    blk.push_back(8'(type_m));
    if (total >= 11 && $urandom_range(0, 5) != 0) begin
      if ($urandom_range(0, 1) == 1) pad_len = 8 + $urandom_range(0, (total < 15) ? total - 11 : 4);
      else pad_len = $urandom_range(8, total - 3);
    end else begin
      pad_len = $urandom_range(0, 7);
    end
    repeat (pad_len)
      blk.push_back(8'(type_m) == pkup_pkg::TYPE_PRIVATE ? pkup_pkg::PAD_FF
                                                           : 8'($urandom_range(1, 255)));
    blk.push_back(SEPARATOR);
    while (blk.size() < total) blk.push_back(8'($urandom_range(0, 255)));
    while (blk.size() > total && blk.size() > 1) void'(blk.pop_back());
  endtask

  task automatic build_block(input int shape);
    int total;
    int pick;
    total = (len_m == 0) ? 1 : int'(len_m);
    if (shape == SHAPE_NOISE) begin
      blk.delete();
      repeat ($urandom_range(1, total + 2)) blk.push_back(8'($urandom_range(0, 255)));
    end else begin
      if (shape == SHAPE_LONG) total += $urandom_range(1, 3);
      else if (shape < SHAPE_CORRUPT && $urandom_range(0, 7) == 0) total += $urandom_range(0, 2) - 1;
      if (total < 1) total = 1;
      build_wellformed(total);
      if (shape == SHAPE_CORRUPT && blk.size() > 1) begin
        pick = $urandom_range(1, blk.size() - 1);
        blk[pick] = 8'($urandom_range(0, 255));
      end
      if (shape == SHAPE_CUT) begin
        pick = $urandom_range(1, (blk.size() < 12) ? blk.size() : 12);
        while (blk.size() > pick) void'(blk.pop_back());
      end
    end
  endtask

  task automatic run_phase(input logic [1:0] bt, input logic [8:0] len, input logic [8:0] cap,
                           input int budget);
    int sent;
    sent = 0;
    set_config(bt, len, cap);
    while (sent < budget) begin
      quiet = ($urandom_range(0, 4) == 0);
      build_block($urandom_range(0, SHAPE_LONG));
      send_block();
      sent += blk.size();
    end
    quiet = 1'b0;
  endtask

  task automatic test_reset_defaults();
    build_wellformed(int'(len_m));
    send_block();
  endtask

  task automatic test_type1_good();
    set_config(BT_PRIVATE, 9'd12, 9'd1);
    blk = {SEPARATOR, pkup_pkg::TYPE_PRIVATE};
    repeat (8) blk.push_back(pkup_pkg::PAD_FF);
    blk.push_back(SEPARATOR);
    blk.push_back(8'hff);
    send_block();
    blk[0]  = 8'hff;
    blk[10] = 8'h00;
    send_block();
  endtask

  task automatic test_early_end();
    set_config(BT_PUBLIC, 9'd1, 9'd256);
    blk = {8'h00};
    send_block();
    set_config(BT_PUBLIC, 9'd2, 9'd256);
    blk = {8'h00, pkup_pkg::TYPE_PUBLIC};
    send_block();
    set_config(BT_PUBLIC, 9'd11, 9'd256);
    blk = {8'h00, pkup_pkg::TYPE_PUBLIC};
    repeat (9) blk.push_back(8'h5a);
    send_block();
    set_config(BT_PUBLIC, 9'd0, 9'd0);
    blk = {8'hff};
    send_block();
  endtask

  // Clean block whose set length runs past the largest supported block.
  task automatic test_overrun();
    set_config(BT_PRIVATE, 9'(pkup_pkg::MAX_BLOCK_BYTES + 2), 9'd511);
    blk = {8'h00, pkup_pkg::TYPE_PRIVATE};
    repeat (8) blk.push_back(pkup_pkg::PAD_FF);
    blk.push_back(SEPARATOR);
    while (blk.size() < int'(len_m)) blk.push_back(8'($urandom_range(0, 255)));
    send_block();
  endtask

  task automatic test_random_type1();
    run_phase(BT_PRIVATE, 9'd11, 9'd0, 8);
    run_phase(BT_PRIVATE, 9'd16, 9'd3, 8);
    run_phase(BT_PRIVATE, 9'($urandom_range(11, 24)), 9'($urandom_range(0, 12)), 8);
  endtask

  task automatic test_random_type2();
    run_phase(BT_PUBLIC, 9'd11, 9'd256, 8);
    run_phase(BT_PUBLIC, 9'd20, 9'd5, 8);
    run_phase(BT_PUBLIC, 9'd5, 9'd2, 8);
    run_phase(BT_PUBLIC, 9'($urandom_range(11, 24)), 9'($urandom_range(0, 12)), 8);
  endtask

  task automatic test_random_unknown_type();
    run_phase(BT_NONE, 9'd12, 9'd8, 8);
    run_phase(BT_RESERVED, 9'd12, 9'd8, 8);
  endtask

  task automatic check_field(input string fname, input logic [8:0] want, input logic [8:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      mismatches++;
    end
  endtask

  // Sample at the falling edge: what is seen here is taken at the next rising edge.
  always @(negedge clk) begin : watch_results
    pkup_pkg::result_t want;
    result_taken = !rst && out_valid && !out_stall;
    if (result_taken) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0h byte %0h status %0h length %0h end %0h",
               out_kind, out_byte, out_status, out_length, out_end);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_kind", want.kind, out_kind);
        check_field("out_byte", want.data, out_byte);
        check_field("out_status", want.status, out_status);
        check_field("out_length", want.length, out_length);
        check_field("out_end", want.done, out_end);
      end
    end
    if (result_taken || (!rst && in_valid && !in_stall)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Draw a fresh stall for each result once the previous one is taken.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (result_taken) begin
      stall_left = draw_wait();
      out_stall <= (stall_left != 0);
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_byte   <= '0;
    in_last   <= 1'b0;
    cfg_en    <= 1'b0;
    cfg_index <= pkup_pkg::REG_BLOCK_TYPE;
    cfg_data  <= '0;
    type_m = pkup_pkg::RESET_BLOCK_TYPE;
    len_m  = pkup_pkg::RESET_BLOCK_LENGTH;
    cap_m  = pkup_pkg::RESET_CAPACITY;
    clear_scan();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_type1_good();
    test_early_end();
    test_overrun();
    test_random_type1();
    test_random_type2();
    test_random_unknown_type();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* pkcs1_v15_unpad_stream_unit.f */
sv/pkup_pkg.sv
sv/pkup_core.sv
sv/pkup_queue.sv
sv/pkcs1_v15_unpad_stream_unit.sv
tb/tb_top.sv
